FILE: sv/slex_pkg.sv
// Shared types and constants for the S-expression token lexer.
`default_nettype none

package slex_pkg;

  // Token kinds carried on the result channel.
  localparam logic [1:0] KindParen  = 2'd0;
  localparam logic [1:0] KindString = 2'd1;
  localparam logic [1:0] KindAtom   = 2'd2;
  localparam logic [1:0] KindError  = 2'd3;

  // Bytes with a special meaning in the text.
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLf     = 8'h0a;
  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChSQuote = 8'h27;
  localparam logic [7:0] ChDQuote = 8'h22;
  localparam logic [7:0] ChError  = 8'h3f;
  localparam logic [7:0] ChNone   = 8'h00;

  // One token event, without the per-item last flag.
  typedef struct packed {
    logic [1:0] token_kind;
    logic [7:0] char_value;
    logic       has_char;
    logic       token_first;
    logic       token_last;
  } event_t;

  // One queue entry: the events caused by one input item.
  typedef struct packed {
    event_t first_ev;
    event_t second_ev;
    logic   two;
  } entry_t;

endpackage

`default_nettype wire

FILE: sv/slex_if.sv
// Handshake interfaces for the lexer's text input and token output channels.
`default_nettype none

interface slex_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface slex_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] token_kind;
  logic [7:0] char_value;
  logic       has_char;
  logic       token_first;
  logic       token_last;
  logic       last;

  modport source (output valid, output token_kind, output char_value, output has_char,
                  output token_first, output token_last, output last, input ready);
  modport sink (input valid, input token_kind, input char_value, input has_char,
                input token_first, input token_last, input last, output ready);
endinterface

`default_nettype wire

FILE: sv/slex_front.sv
// Front end: classifies each text byte, tracks the lexer mode and forms token events.
`default_nettype none

module slex_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [7:0]      text_byte_i,
  input  wire logic            end_of_text_i,
  input  wire logic            accept_i,
  output slex_pkg::entry_t     entry_o,
  output logic                 push_o
);

  typedef enum logic [1:0] {
    ModeIdle   = 2'd0,
    ModeAtom   = 2'd1,
    ModeString = 2'd2
  } mode_e;

  mode_e mode_q, mode_d;
  logic  quote_q, quote_d;

  // Decode the byte against the current mode.
  always_comb begin
    slex_pkg::event_t ev0, ev1, new_ev;
    logic       is_space, paren_hit, quote_hit, special, free, have0, have_new;
    logic [7:0] closer;
    ev0       = '0;
    ev1       = '0;
    new_ev    = '0;
    have0     = 1'b0;
    have_new  = 1'b0;
    free      = 1'b0;
    mode_d    = mode_q;
    quote_d   = quote_q;
    is_space  = (text_byte_i == slex_pkg::ChSpace) || (text_byte_i == slex_pkg::ChTab) ||
                (text_byte_i == slex_pkg::ChLf) || (text_byte_i == slex_pkg::ChCr);
    paren_hit = (text_byte_i == slex_pkg::ChLParen) || (text_byte_i == slex_pkg::ChRParen);
    quote_hit = (text_byte_i == slex_pkg::ChSQuote) || (text_byte_i == slex_pkg::ChDQuote);
    special   = is_space || paren_hit || quote_hit;
    closer    = quote_q ? slex_pkg::ChDQuote : slex_pkg::ChSQuote;

    if (end_of_text_i) begin
      // End of text flushes an open atom or reports an open string.
      case (mode_q)
        ModeAtom: begin
          ev0   = '{slex_pkg::KindAtom, slex_pkg::ChNone, 1'b0, 1'b0, 1'b1};
          have0 = 1'b1;
        end
        ModeString: begin
          ev0   = '{slex_pkg::KindError, slex_pkg::ChError, 1'b0, 1'b1, 1'b1};
          have0 = 1'b1;
        end
        default: ;
      endcase
      mode_d = ModeIdle;
    end else if (mode_q == ModeString) begin
      have0 = 1'b1;
      if (text_byte_i == closer) begin
        ev0    = '{slex_pkg::KindString, slex_pkg::ChNone, 1'b0, 1'b0, 1'b1};
        mode_d = ModeIdle;
      end else begin
        ev0 = '{slex_pkg::KindString, text_byte_i, 1'b1, 1'b0, 1'b0};
      end
    end else begin
      // An open atom either grows or ends; an ended atom frees the byte.
      if (mode_q == ModeAtom) begin
        have0 = 1'b1;
        if (!special) begin
          ev0 = '{slex_pkg::KindAtom, text_byte_i, 1'b1, 1'b0, 1'b0};
        end else begin
          ev0  = '{slex_pkg::KindAtom, slex_pkg::ChNone, 1'b0, 1'b0, 1'b1};
          free = 1'b1;
        end
      end else begin
        free = 1'b1;
      end
      if (free) begin
        mode_d = ModeIdle;
        if (paren_hit) begin
          new_ev   = '{slex_pkg::KindParen, text_byte_i, 1'b0, 1'b1, 1'b1};
          have_new = 1'b1;
        end else if (quote_hit) begin
          new_ev   = '{slex_pkg::KindString, slex_pkg::ChNone, 1'b0, 1'b1, 1'b0};
          have_new = 1'b1;
          quote_d  = (text_byte_i == slex_pkg::ChDQuote);
          mode_d   = ModeString;
        end else if (!special) begin
          new_ev   = '{slex_pkg::KindAtom, text_byte_i, 1'b1, 1'b1, 1'b0};
          have_new = 1'b1;
          mode_d   = ModeAtom;
        end
      end
    end

    // A new token's event follows an atom end, or stands alone.
    if (have_new) begin
      if (have0) begin
        ev1 = new_ev;
      end else begin
        ev0 = new_ev;
      end
    end

    entry_o.first_ev  = ev0;
    entry_o.second_ev = ev1;
    entry_o.two       = have0 && have_new;
    push_o            = accept_i && (have0 || have_new);
  end

  // Mode state advances on every accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      quote_q <= 1'b0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      quote_q <= quote_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/slex_queue.sv
// Small queue of event entries between the front end and the back end.
`default_nettype none

module slex_queue #(
  parameter int Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire slex_pkg::entry_t push_entry_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output slex_pkg::entry_t      head_o,
  output logic                  empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  slex_pkg::entry_t slots_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/slex_back.sv
// Back end: sends the events of each queue entry, one transfer per cycle while out_ready_i is high.
`default_nettype none

module slex_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire slex_pkg::entry_t head_i,
  input  wire logic             empty_i,
  output logic                  pop_o,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  output slex_pkg::event_t      out_ev_o,
  output logic                  out_last_o
);

  logic             valid_q;
  logic             second_q;
  slex_pkg::event_t ev_q;
  logic             last_q;
  logic             load;

  // The output register takes a new event whenever an entry waits and the register is empty or drained.
  assign load        = !empty_i && (!valid_q || out_ready_i);
  assign pop_o       = load && (second_q || !head_i.two);
  assign out_valid_o = valid_q;
  assign out_ev_o    = ev_q;
  assign out_last_o  = last_q;

  // Control: output valid and which event of the head entry goes next.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q  <= 1'b1;
        second_q <= !second_q && head_i.two;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      ev_q   <= second_q ? head_i.second_ev : head_i.first_ev;
      last_q <= second_q || !head_i.two;
    end
  end

endmodule

`default_nettype wire

FILE: sv/sexpr_token_lexer_core.sv
// Top level of the S-expression token lexer: front end, event queue and back end.
// Events are registered in a queue slot, then in the output register. Throughput:
// one item per cycle while the queue has room; one event leaves per cycle while
// output is ready, so an item with two events makes two transfers as the queue
// keeps taking items. QueueDepth entries bound how far input runs ahead of output.
// Reset: asynchronous, active low; clears the lexer mode, queue and output valid.
`default_nettype none

module sexpr_token_lexer_core #(
  parameter int QueueDepth = 4
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  slex_in_if.sink      in_i,
  slex_out_if.source   out_o
);

  slex_pkg::entry_t push_entry, head;
  slex_pkg::event_t out_ev;
  logic             push, full, pop, empty, accept;

  // Input transfer happens whenever the queue has room.
  assign in_i.ready = !full;
  assign accept     = in_i.valid && !full;

  slex_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .text_byte_i   (in_i.text_byte),
    .end_of_text_i (in_i.end_of_text),
    .accept_i      (accept),
    .entry_o       (push_entry),
    .push_o        (push)
  );

  slex_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .head_o       (head),
    .empty_o      (empty)
  );

  slex_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_ev_o    (out_ev),
    .out_last_o  (out_o.last)
  );

  // Unpack the event onto the output channel.
  assign out_o.token_kind  = out_ev.token_kind;
  assign out_o.char_value  = out_ev.char_value;
  assign out_o.has_char    = out_ev.has_char;
  assign out_o.token_first = out_ev.token_first;
  assign out_o.token_last  = out_ev.token_last;

endmodule

`default_nettype wire

FILE: tb/tb_sexpr_token_lexer_core.sv
// Self-checking testbench for the S-expression token lexer core.
`timescale 1ns / 1ps

module tb_sexpr_token_lexer_core;

  localparam int unsigned CycleLimit  = 600_000;
  localparam int unsigned RandomItems = 800;

  // Lexer state as the scoreboard tracks it.
  typedef enum logic [1:0] {ModeIdle, ModeAtom, ModeString} lex_mode_e;

  // One token event with the per-item last flag.
  typedef struct packed {
    slex_pkg::event_t ev;
    logic             last;
  } token_rec_t;

  // One pending text item; drain makes the driver wait for all tokens first.
  typedef struct {
    logic [7:0] text_byte;
    logic       eot;
    logic       drain;
  } text_item_t;

  logic clk;
  logic rst_n;

  slex_in_if  in_ch ();
  slex_out_if out_ch ();

  sexpr_token_lexer_core dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  text_item_t  text_q[$];
  token_rec_t  token_q[$];
  lex_mode_e   lex_mode;
  logic        dq_close;

  int unsigned stim_cnt;
  int unsigned items_sent;
  int unsigned eot_sent;
  int unsigned tokens_seen;
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned gap_left;
  int unsigned stall_left;
  bit          in_calm;
  bit          out_calm;
  text_item_t  nxt_item;
  token_rec_t  exp_tok;

  // Clock and cycle counter.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // Known values on every input from time zero.
  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.text_byte      = 8'h00;
    in_ch.end_of_text    = 1'b0;
    out_ch.ready         = 1'b0;
    lex_mode             = ModeIdle;
    dq_close             = 1'b0;
    cycle_cnt            = 0;
    items_sent           = 0;
    eot_sent             = 0;
    tokens_seen          = 0;
    err_cnt              = 0;
    gap_left             = 0;
    stall_left           = 0;
    in_calm              = 1'b0;
    out_calm             = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic bit is_space(logic [7:0] c);
    return c == slex_pkg::ChSpace || c == slex_pkg::ChTab ||
           c == slex_pkg::ChLf || c == slex_pkg::ChCr;
  endfunction

  function automatic bit is_paren_ch(logic [7:0] c);
    return c == slex_pkg::ChLParen || c == slex_pkg::ChRParen;
  endfunction

  function automatic bit is_quote_ch(logic [7:0] c);
    return c == slex_pkg::ChSQuote || c == slex_pkg::ChDQuote;
  endfunction

  function automatic slex_pkg::event_t mk_ev(logic [1:0] kind, logic [7:0] ch, logic has,
                                             logic first, logic lastt);
    slex_pkg::event_t e;
    e.token_kind  = kind;
    e.char_value  = ch;
    e.has_char    = has;
    e.token_first = first;
    e.token_last  = lastt;
    return e;
  endfunction

  // Gap length: mostly short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(3, 1);
    else if (r < 97) return $urandom_range(10, 4);
    else return $urandom_range(60, 20);
  endfunction

  // Any byte that starts or continues an atom.
  function automatic logic [7:0] atom_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (is_space(b) || is_paren_ch(b) || is_quote_ch(b));
    return b;
  endfunction

  // Tokenize one accepted item and queue the token events it produces.
  task automatic lex_step(input logic [7:0] c, input logic eot);
    slex_pkg::event_t evs[2];
    int               n;
    bit               special;
    n = 0;
    if (eot) begin
      if (lex_mode == ModeAtom) begin
        evs[n] = mk_ev(slex_pkg::KindAtom, slex_pkg::ChNone, 1'b0, 1'b0, 1'b1);
        n++;
      end else if (lex_mode == ModeString) begin
        // An unterminated string turns into a single error token.
        evs[n] = mk_ev(slex_pkg::KindError, slex_pkg::ChError, 1'b0, 1'b1, 1'b1);
        n++;
      end
      lex_mode = ModeIdle;
    end else if (lex_mode == ModeString) begin
      if (c == (dq_close ? slex_pkg::ChDQuote : slex_pkg::ChSQuote)) begin
        evs[n] = mk_ev(slex_pkg::KindString, slex_pkg::ChNone, 1'b0, 1'b0, 1'b1);
        n++;
        lex_mode = ModeIdle;
      end else begin
        evs[n] = mk_ev(slex_pkg::KindString, c, 1'b1, 1'b0, 1'b0);
        n++;
      end
    end else begin
      special = is_space(c) || is_paren_ch(c) || is_quote_ch(c);
      // A special byte closes an open atom and is then handled from idle.
      if (lex_mode == ModeAtom) begin
        if (!special) begin
          evs[n] = mk_ev(slex_pkg::KindAtom, c, 1'b1, 1'b0, 1'b0);
          n++;
        end else begin
          evs[n] = mk_ev(slex_pkg::KindAtom, slex_pkg::ChNone, 1'b0, 1'b0, 1'b1);
          n++;
          lex_mode = ModeIdle;
        end
      end
      if (lex_mode != ModeAtom) begin
        if (is_paren_ch(c)) begin
          evs[n] = mk_ev(slex_pkg::KindParen, c, 1'b0, 1'b1, 1'b1);
          n++;
        end else if (is_quote_ch(c)) begin
          evs[n] = mk_ev(slex_pkg::KindString, slex_pkg::ChNone, 1'b0, 1'b1, 1'b0);
          n++;
          dq_close = (c == slex_pkg::ChDQuote);
          lex_mode = ModeString;
        end else if (!special) begin
          evs[n] = mk_ev(slex_pkg::KindAtom, c, 1'b1, 1'b1, 1'b0);
          n++;
          lex_mode = ModeAtom;
        end
      end
    end
    for (int i = 0; i < n; i++) token_q.push_back('{ev: evs[i], last: (i == n - 1)});
  endtask

  task automatic add_item(input logic [7:0] c, input logic eot, input logic drain = 1'b0);
    text_q.push_back('{text_byte: c, eot: eot, drain: drain});
    stim_cnt++;
  endtask

  // Driver: offers pending items with random gaps and holds each until its transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        lex_step(in_ch.text_byte, in_ch.end_of_text);
        items_sent++;
        if (in_ch.end_of_text) eot_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (text_q.size() > 0 && !(text_q[0].drain && token_q.size() > 0)) begin
          nxt_item = text_q.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.text_byte   <= nxt_item.text_byte;
          in_ch.end_of_text <= nxt_item.eot;
          if ($urandom_range(99) < 3) in_calm = !in_calm;
          gap_left = in_calm ? 0 : pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each token transfer against the oldest expectation and stalls at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        tokens_seen++;
        if (token_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("error: token event with none expected: kind=%0d ch=%02h",
                     out_ch.token_kind, out_ch.char_value);
        end else begin
          exp_tok = token_q.pop_front();
          if (out_ch.token_kind !== exp_tok.ev.token_kind ||
              out_ch.char_value !== exp_tok.ev.char_value ||
              out_ch.has_char !== exp_tok.ev.has_char ||
              out_ch.token_first !== exp_tok.ev.token_first ||
              out_ch.token_last !== exp_tok.ev.token_last ||
              out_ch.last !== exp_tok.last) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("error: event %0d: exp kind=%0d ch=%02h has=%0b first=%0b tlast=%0b",
                       tokens_seen, exp_tok.ev.token_kind, exp_tok.ev.char_value,
                       exp_tok.ev.has_char, exp_tok.ev.token_first,
                       exp_tok.ev.token_last);
              $display("       exp last=%0b, got kind=%0d ch=%02h has=%0b first=%0b",
                       exp_tok.last, out_ch.token_kind, out_ch.char_value,
                       out_ch.has_char, out_ch.token_first);
              $display("       got tlast=%0b last=%0b", out_ch.token_last, out_ch.last);
            end
          end
        end
      end
      if ($urandom_range(99) < 1) out_calm = !out_calm;
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!out_calm && $urandom_range(99) < 20) begin
        stall_left = pick_gap();
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Timeout guard.
  initial begin
    while (cycle_cnt < CycleLimit) @(posedge clk);
    $display("error: timeout after %0d cycles, %0d events outstanding",
             cycle_cnt, token_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    int unsigned r;
    int unsigned len;
    bit          drained;
    logic [7:0]  quote;
    logic [7:0]  c;
    stim_cnt = 0;
    drained  = 1'b0;

    // End of text while idle, with a byte that must be ignored.
    add_item(8'hff, 1'b1);
    add_item(slex_pkg::ChLParen, 1'b0);
    add_item(slex_pkg::ChRParen, 1'b0);
    add_item(slex_pkg::ChSpace, 1'b0);
    add_item(slex_pkg::ChTab, 1'b0);
    add_item(slex_pkg::ChLf, 1'b0);
    add_item(slex_pkg::ChCr, 1'b0);
    // Atom of extreme byte values, closed by a paren.
    add_item(8'h00, 1'b0);
    add_item(8'hff, 1'b0);
    add_item(8'h80, 1'b0);
    add_item(8'h7f, 1'b0);
    add_item(slex_pkg::ChLParen, 1'b0);
    // Atom closed by a double quote; the other quote and specials are string content.
    add_item(8'h61, 1'b0);
    add_item(slex_pkg::ChDQuote, 1'b0);
    add_item(slex_pkg::ChSQuote, 1'b0);
    add_item(slex_pkg::ChSpace, 1'b0);
    add_item(slex_pkg::ChLParen, 1'b0);
    add_item(slex_pkg::ChDQuote, 1'b0);
    // Atom closed by a single quote; the string is cut off by end of text.
    add_item(8'h62, 1'b0);
    add_item(slex_pkg::ChSQuote, 1'b0);
    add_item(slex_pkg::ChDQuote, 1'b0);
    add_item(8'h00, 1'b1);
    // Atom closed by whitespace, then an atom closed by end of text.
    add_item(8'h63, 1'b0);
    add_item(slex_pkg::ChSpace, 1'b0);
    add_item(8'h7a, 1'b0);
    add_item(8'h55, 1'b1);
    // Empty string.
    add_item(slex_pkg::ChSQuote, 1'b0);
    add_item(slex_pkg::ChSQuote, 1'b0);

    // Random text: mostly well-formed tokens, some raw noise.
    while (stim_cnt < RandomItems + 28) begin
      if (!drained && stim_cnt >= 400) begin
        add_item(slex_pkg::ChSpace, 1'b0, 1'b1);
        drained = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 25) begin
        len = $urandom_range(6, 1);
        repeat (len) add_item(atom_byte(), 1'b0);
      end else if (r < 45) begin
        quote = $urandom_range(1) ? slex_pkg::ChDQuote : slex_pkg::ChSQuote;
        add_item(quote, 1'b0);
        len = $urandom_range(8, 0);
        repeat (len) begin
          do c = 8'($urandom_range(255));
          while (c == quote);
          add_item(c, 1'b0);
        end
        if ($urandom_range(99) < 85) add_item(quote, 1'b0);
        else add_item(8'($urandom_range(255)), 1'b1);
      end else if (r < 60) begin
        add_item($urandom_range(1) ? slex_pkg::ChLParen : slex_pkg::ChRParen, 1'b0);
      end else if (r < 72) begin
        len = $urandom_range(3, 1);
        repeat (len) begin
          case ($urandom_range(3))
            0: add_item(slex_pkg::ChSpace, 1'b0);
            1: add_item(slex_pkg::ChTab, 1'b0);
            2: add_item(slex_pkg::ChLf, 1'b0);
            default: add_item(slex_pkg::ChCr, 1'b0);
          endcase
        end
      end else if (r < 78) begin
        add_item(8'($urandom_range(255)), 1'b1);
      end else begin
        len = $urandom_range(4, 1);
        repeat (len) add_item(8'($urandom_range(255)), ($urandom_range(9) == 0));
      end
    end
    add_item(8'h00, 1'b1);

    // Wait for every item to be taken and every token to arrive.
    @(posedge rst_n);
    while (text_q.size() != 0 || in_ch.valid) @(posedge clk);
    while (token_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Lexed %0d text items (%0d end-of-text markers) into %0d token events.",
             items_sent, eot_sent, tokens_seen);
    $display("Mismatches or stray events: %0d, expectations left over: %0d.",
             err_cnt, token_q.size());
    if (err_cnt == 0 && token_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
